>>> rtl/gajm_pkg.sv
// Package for the greedy angle jet matcher: item and vector types,
// command codes and fixed-point limits. No dependencies.
package gajm_pkg;

    // Command codes carried by an input item
    localparam logic CMD_FERMION = 1'b0;
    localparam logic CMD_JET     = 1'b1;

    // Neutrino codes (absolute value), dropped on load
    localparam logic [15:0] CODE_NU_E   = 16'd12;
    localparam logic [15:0] CODE_NU_MU  = 16'd14;
    localparam logic [15:0] CODE_NU_TAU = 16'd16;

    // Q1.15 cosine limits
    localparam logic signed [15:0] COS_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COS_MIN = 16'sh8000;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    // One classified item in the queue
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [15:0] code;
        logic               final_item;
        logic               drop;
    } t_item;

    // Scaled momentum vector with its squared norm
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic [31:0]        norm;
        logic               nz;
    } t_vec;

endpackage

>>> rtl/gajm_in_if.sv
// Input channel of the jet matcher: valid/ready plus one load item.
// No dependencies.
interface gajm_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [15:0] particle_code;
    logic               final_item;

    modport source (output valid, cmd, mom_x, mom_y, mom_z, particle_code, final_item,
                    input ready);
    modport sink   (input valid, cmd, mom_x, mom_y, mom_z, particle_code, final_item,
                    output ready);
endinterface

>>> rtl/gajm_out_if.sv
// Result channel of the jet matcher: valid/ready plus one jet result.
// No dependencies.
interface gajm_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         jet_slot;
    logic signed [15:0] tag_code;
    logic signed [15:0] cos_psi;
    logic signed [19:0] cos_total;
    logic               was_matched;
    logic               is_last;
    logic               overflow_seen;

    modport source (output valid, jet_slot, tag_code, cos_psi, cos_total, was_matched,
                    is_last, overflow_seen, input ready);
    modport sink   (input valid, jet_slot, tag_code, cos_psi, cos_total, was_matched,
                    is_last, overflow_seen, output ready);
endinterface

>>> rtl/gajm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gajm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/gajm_front.sv
// Front end: accepts load items, flags neutrinos for dropping and queues
// them for the back end. Depends on gajm_pkg and gajm_in_if.
module gajm_front
    import gajm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gajm_in_if.sink   i_in,
    output t_item     o_item,
    output logic      o_item_valid,
    input  logic      i_item_ready
);
    localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_item            r_q [QDEPTH];
    logic [QPW-1:0]   r_wp, n_wp;
    logic [QPW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             w_push, w_pop;
    logic [15:0]      w_abs;
    t_item            w_new;

    // Classify: fermions with a neutrino code are marked for dropping
    always_comb begin
        w_abs = i_in.particle_code[15] ? (16'd0 - i_in.particle_code) : i_in.particle_code;
        w_new.cmd        = i_in.cmd;
        w_new.mom_x      = i_in.mom_x;
        w_new.mom_y      = i_in.mom_y;
        w_new.mom_z      = i_in.mom_z;
        w_new.code       = i_in.particle_code;
        w_new.final_item = i_in.final_item;
        w_new.drop       = (i_in.cmd == CMD_FERMION) &&
                           (w_abs inside {CODE_NU_E, CODE_NU_MU, CODE_NU_TAU});
    end

    assign i_in.ready   = (r_cnt != QCW'(QDEPTH));
    assign w_push       = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != '0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rp];

    // Queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + QPW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + QPW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end
endmodule

>>> rtl/gajm_back.sv
// Back end: stores scaled vectors, builds the cosine matrix with a shared
// square-root and divider, runs the greedy passes and emits one result per
// jet. Depends on gajm_pkg, gajm_out_if and gajm_ram.
module gajm_back
    import gajm_pkg::*;
#(
    parameter int MAX_FERMIONS = 4,
    parameter int MAX_JETS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    gajm_out_if.source  o_out
);
    localparam int FW   = (MAX_FERMIONS > 1) ? $clog2(MAX_FERMIONS) : 1;
    localparam int JW   = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
    localparam int FCW  = $clog2(MAX_FERMIONS + 1);
    localparam int JCW  = $clog2(MAX_JETS + 1);
    localparam int CW   = (FCW > JCW) ? FCW : JCW;
    localparam int MD   = MAX_FERMIONS * MAX_JETS;
    localparam int AW   = (MD > 1) ? $clog2(MD) : 1;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SCALE = 5'd1;
    localparam logic [4:0] ST_NORM  = 5'd2;
    localparam logic [4:0] ST_STORE = 5'd3;
    localparam logic [4:0] ST_DOT   = 5'd4;
    localparam logic [4:0] ST_PROD  = 5'd5;
    localparam logic [4:0] ST_SQRT  = 5'd6;
    localparam logic [4:0] ST_DSET  = 5'd7;
    localparam logic [4:0] ST_DIV   = 5'd8;
    localparam logic [4:0] ST_WRCOS = 5'd9;
    localparam logic [4:0] ST_SCAN  = 5'd10;
    localparam logic [4:0] ST_RD    = 5'd11;
    localparam logic [4:0] ST_CMP   = 5'd12;
    localparam logic [4:0] ST_APPLY = 5'd13;
    localparam logic [4:0] ST_SUM   = 5'd14;
    localparam logic [4:0] ST_EMIT  = 5'd15;
    localparam logic [4:0] ST_CLEAR = 5'd16;

    // Control state
    logic [4:0]          r_state, n_state;
    logic [FCW-1:0]      r_fc, n_fc;
    logic [JCW-1:0]      r_jc, n_jc;
    logic                r_ovf, n_ovf;
    logic                r_ftaken [MAX_FERMIONS];
    logic                n_ftaken [MAX_FERMIONS];
    logic                r_jtaken [MAX_JETS];
    logic                n_jtaken [MAX_JETS];
    logic signed [15:0]  r_tag [MAX_JETS];
    logic signed [15:0]  n_tag [MAX_JETS];
    logic signed [15:0]  r_cos [MAX_JETS];
    logic signed [15:0]  n_cos [MAX_JETS];
    logic                r_ov, n_ov;

    // Working registers
    logic [31:0]         r_mag [3];
    logic [31:0]         n_mag [3];
    logic [2:0]          r_neg, n_neg;
    logic [1:0]          r_k, n_k;
    logic [31:0]         r_norm, n_norm;
    logic                r_is_jet, n_is_jet;
    logic                r_final, n_final;
    logic signed [15:0]  r_code, n_code;
    t_vec                r_fvec [MAX_FERMIONS];
    t_vec                n_fvec [MAX_FERMIONS];
    logic signed [15:0]  r_fcode [MAX_FERMIONS];
    logic signed [15:0]  n_fcode [MAX_FERMIONS];
    t_vec                r_jvec [MAX_JETS];
    t_vec                n_jvec [MAX_JETS];
    logic [FW-1:0]       r_f, n_f;
    logic [JW-1:0]       r_j, n_j;
    logic signed [33:0]  r_dot, n_dot;
    logic                r_zero, n_zero;
    logic                r_dneg, n_dneg;
    logic [31:0]         r_ad, n_ad;
    logic [63:0]         r_rad, n_rad;
    logic [35:0]         r_rem, n_rem;
    logic [31:0]         r_root, n_root;
    logic [5:0]          r_step, n_step;
    logic [47:0]         r_num, n_num;
    logic [31:0]         r_drem, n_drem;
    logic [47:0]         r_q, n_q;
    logic [CW-1:0]       r_pass, n_pass;
    logic                r_found, n_found;
    logic signed [15:0]  r_best, n_best;
    logic [FW-1:0]       r_bf, n_bf;
    logic [JW-1:0]       r_bj, n_bj;
    logic signed [19:0]  r_total, n_total;
    logic [JW-1:0]       r_oj, n_oj;

    // Output payload
    logic [3:0]          r_o_slot, n_o_slot;
    logic signed [15:0]  r_o_tag, n_o_tag;
    logic signed [15:0]  r_o_cos, n_o_cos;
    logic signed [19:0]  r_o_total, n_o_total;
    logic                r_o_matched, n_o_matched;
    logic                r_o_last, n_o_last;
    logic                r_o_ovf, n_o_ovf;

    // Cosine matrix memory
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_addr;
    logic [15:0]         w_ram_wdata;
    logic [15:0]         w_ram_rdata;

    gajm_ram #(
        .WIDTH (16),
        .DEPTH (MD)
    ) u_cos_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_addr),
        .o_rdata (w_ram_rdata)
    );

    assign w_ram_addr = AW'(r_f) * AW'(MAX_JETS) + AW'(r_j);

    // Temporaries
    t_vec                w_fv, w_jv, w_vec;
    logic signed [15:0]  w_fa, w_ja;
    logic signed [31:0]  w_prod;
    logic [29:0]         w_sq;
    logic [35:0]         w_rem2, w_trial;
    logic [32:0]         w_drem2;
    logic                w_qbit;
    logic signed [15:0]  w_cosv, w_c;
    logic [CW-1:0]       w_passes;
    logic                w_flast, w_jlast, w_olast;
    logic signed [15:0]  w_comp [3];

    assign o_out.valid         = r_ov;
    assign o_out.jet_slot      = r_o_slot;
    assign o_out.tag_code      = r_o_tag;
    assign o_out.cos_psi       = r_o_cos;
    assign o_out.cos_total     = r_o_total;
    assign o_out.was_matched   = r_o_matched;
    assign o_out.is_last       = r_o_last;
    assign o_out.overflow_seen = r_o_ovf;

    always_comb begin
        // defaults: hold
        n_state = r_state;  n_fc = r_fc;  n_jc = r_jc;  n_ovf = r_ovf;
        n_ftaken = r_ftaken; n_jtaken = r_jtaken; n_tag = r_tag; n_cos = r_cos;
        n_ov = r_ov && !o_out.ready;
        n_mag = r_mag;  n_neg = r_neg;  n_k = r_k;  n_norm = r_norm;
        n_is_jet = r_is_jet;  n_final = r_final;  n_code = r_code;
        n_fvec = r_fvec;  n_fcode = r_fcode;  n_jvec = r_jvec;
        n_f = r_f;  n_j = r_j;  n_dot = r_dot;  n_zero = r_zero;  n_dneg = r_dneg;
        n_ad = r_ad;  n_rad = r_rad;  n_rem = r_rem;  n_root = r_root;  n_step = r_step;
        n_num = r_num;  n_drem = r_drem;  n_q = r_q;
        n_pass = r_pass;  n_found = r_found;  n_best = r_best;  n_bf = r_bf;  n_bj = r_bj;
        n_total = r_total;  n_oj = r_oj;
        n_o_slot = r_o_slot;  n_o_tag = r_o_tag;  n_o_cos = r_o_cos;
        n_o_total = r_o_total;  n_o_matched = r_o_matched;  n_o_last = r_o_last;
        n_o_ovf = r_o_ovf;
        w_ram_we = 1'b0;
        w_ram_wdata = '0;
        o_item_ready = (r_state == ST_IDLE);

        w_fv = r_fvec[r_f];
        w_jv = r_jvec[r_j];
        case (r_k)
            2'd0:    begin w_fa = w_fv.cx; w_ja = w_jv.cx; end
            2'd1:    begin w_fa = w_fv.cy; w_ja = w_jv.cy; end
            default: begin w_fa = w_fv.cz; w_ja = w_jv.cz; end
        endcase
        w_prod = w_fa * w_ja;
        w_sq   = r_mag[r_k][14:0] * r_mag[r_k][14:0];
        for (int k = 0; k < 3; k++) begin
            w_comp[k] = r_neg[k] ? (16'sd0 - $signed({1'b0, r_mag[k][14:0]}))
                                 : $signed({1'b0, r_mag[k][14:0]});
        end
        w_vec.cx   = w_comp[0];
        w_vec.cy   = w_comp[1];
        w_vec.cz   = w_comp[2];
        w_vec.norm = r_norm;
        w_vec.nz   = |{r_mag[0][14:0], r_mag[1][14:0], r_mag[2][14:0]};

        w_rem2  = {r_rem[33:0], r_rad[63:62]};
        w_trial = {2'b00, r_root, 2'b01};
        w_drem2 = {r_drem, r_num[47]};
        w_qbit  = (w_drem2 >= {1'b0, r_root});

        // saturated signed quotient
        if (r_zero) begin
            w_cosv = 16'sd0;
        end else if (r_dneg) begin
            w_cosv = (r_q > 48'd32768) ? COS_MIN : $signed(16'(17'd0 - r_q[16:0]));
        end else begin
            w_cosv = (r_q > 48'd32767) ? COS_MAX : $signed(r_q[15:0]);
        end

        w_c      = $signed(w_ram_rdata);
        w_passes = (CW'(r_fc) < CW'(r_jc)) ? CW'(r_fc) : CW'(r_jc);
        w_flast  = (FCW'(r_f) + FCW'(1) == r_fc);
        w_jlast  = (JCW'(r_j) + JCW'(1) == r_jc);
        w_olast  = (JCW'(r_oj) + JCW'(1) == r_jc);

        case (r_state)
            // take one item from the queue
            ST_IDLE: begin
                if (i_item_valid) begin
                    for (int k = 0; k < 3; k++) begin
                        n_neg[k] = 1'b0;
                    end
                    n_neg[0] = i_item.mom_x[31];
                    n_neg[1] = i_item.mom_y[31];
                    n_neg[2] = i_item.mom_z[31];
                    n_mag[0] = i_item.mom_x[31] ? 32'd0 - i_item.mom_x : i_item.mom_x;
                    n_mag[1] = i_item.mom_y[31] ? 32'd0 - i_item.mom_y : i_item.mom_y;
                    n_mag[2] = i_item.mom_z[31] ? 32'd0 - i_item.mom_z : i_item.mom_z;
                    n_code   = i_item.code;
                    n_final  = i_item.final_item;
                    if (i_item.cmd == CMD_FERMION) begin
                        n_is_jet = 1'b0;
                        if (!i_item.drop) begin
                            if (r_fc == FCW'(MAX_FERMIONS)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_state = ST_SCALE;
                            end
                        end
                    end else begin
                        n_is_jet = 1'b1;
                        if (r_jc == JCW'(MAX_JETS)) begin
                            n_ovf = 1'b1;
                            if (i_item.final_item) begin
                                n_f = '0;  n_j = '0;  n_k = '0;  n_dot = '0;  n_pass = '0;
                                n_state = (r_fc == '0) ? ST_SCAN : ST_DOT;
                            end
                        end else begin
                            n_state = ST_SCALE;
                        end
                    end
                end
            end
            // shift until every magnitude fits in 15 bits
            ST_SCALE: begin
                if (|{r_mag[0][31:15], r_mag[1][31:15], r_mag[2][31:15]}) begin
                    for (int k = 0; k < 3; k++) begin
                        n_mag[k] = r_mag[k] >> 1;
                    end
                end else begin
                    n_k = '0;
                    n_norm = '0;
                    n_state = ST_NORM;
                end
            end
            // squared norm, one component a cycle
            ST_NORM: begin
                n_norm = r_norm + 32'(w_sq);
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (r_is_jet) begin
                    n_jvec[r_jc[JW-1:0]] = w_vec;
                    n_jc = r_jc + JCW'(1);
                    if (r_final) begin
                        n_f = '0;  n_j = '0;  n_k = '0;  n_dot = '0;  n_pass = '0;
                        n_state = (r_fc == '0) ? ST_SCAN : ST_DOT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_fvec[r_fc[FW-1:0]]  = w_vec;
                    n_fcode[r_fc[FW-1:0]] = r_code;
                    n_fc = r_fc + FCW'(1);
                    n_state = ST_IDLE;
                end
            end
            // dot product, one term a cycle
            ST_DOT: begin
                n_dot = r_dot + 34'(w_prod);
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                n_zero = !(w_fv.nz && w_jv.nz);
                n_rad  = w_fv.norm * w_jv.norm;
                n_dneg = r_dot[33];
                n_ad   = r_dot[33] ? 32'(34'sd0 - r_dot) : r_dot[31:0];
                n_rem  = '0;
                n_root = '0;
                n_step = '0;
                n_state = (!(w_fv.nz && w_jv.nz)) ? ST_WRCOS : ST_SQRT;
            end
            // integer square root, two radicand bits a cycle
            ST_SQRT: begin
                n_rad = r_rad << 2;
                if (w_rem2 >= w_trial) begin
                    n_rem  = w_rem2 - w_trial;
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem  = w_rem2;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_step = r_step + 6'd1;
                if (r_step == 6'd31) begin
                    n_state = ST_DSET;
                end
            end
            ST_DSET: begin
                n_num  = {1'b0, r_ad, 15'd0} + 48'(r_root >> 1);
                n_drem = '0;
                n_q    = '0;
                n_step = '0;
                if (r_root == '0) begin
                    n_zero = 1'b1;
                    n_state = ST_WRCOS;
                end else begin
                    n_state = ST_DIV;
                end
            end
            // restoring division, one quotient bit a cycle
            ST_DIV: begin
                n_num  = r_num << 1;
                n_drem = w_qbit ? 32'(w_drem2 - {1'b0, r_root}) : w_drem2[31:0];
                n_q    = {r_q[46:0], w_qbit};
                n_step = r_step + 6'd1;
                if (r_step == 6'd47) begin
                    n_state = ST_WRCOS;
                end
            end
            ST_WRCOS: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = w_cosv;
                n_k   = '0;
                n_dot = '0;
                if (w_jlast) begin
                    n_j = '0;
                    if (w_flast) begin
                        n_f = '0;
                        n_pass = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_f = r_f + FW'(1);
                        n_state = ST_DOT;
                    end
                end else begin
                    n_j = r_j + JW'(1);
                    n_state = ST_DOT;
                end
            end
            // greedy passes: each scans every fermion/jet pair and takes the best free one
            ST_SCAN: begin
                n_f = '0;
                n_j = '0;
                n_found = 1'b0;
                if (r_pass == w_passes) begin
                    n_oj = '0;
                    n_total = '0;
                    n_state = (r_jc == '0) ? ST_CLEAR : ST_SUM;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!r_ftaken[r_f] && !r_jtaken[r_j] && (!r_found || w_c > r_best)) begin
                    n_found = 1'b1;
                    n_best  = w_c;
                    n_bf    = r_f;
                    n_bj    = r_j;
                end
                n_state = ST_RD;
                if (w_jlast) begin
                    n_j = '0;
                    if (w_flast) begin
                        n_state = ST_APPLY;
                    end else begin
                        n_f = r_f + FW'(1);
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            ST_APPLY: begin
                if (r_found) begin
                    n_ftaken[r_bf] = 1'b1;
                    n_jtaken[r_bj] = 1'b1;
                    n_tag[r_bj]    = r_fcode[r_bf];
                    n_cos[r_bj]    = r_best;
                    n_pass  = r_pass + CW'(1);
                    n_state = ST_SCAN;
                end else begin
                    n_oj = '0;
                    n_total = '0;
                    n_state = ST_SUM;
                end
            end
            // total of the jet cosines
            ST_SUM: begin
                n_total = r_total + 20'(r_cos[r_oj]);
                if (w_olast) begin
                    n_oj = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_oj = r_oj + JW'(1);
                end
            end
            // one result per jet into the output register
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov        = 1'b1;
                    n_o_slot    = 4'(r_oj);
                    n_o_tag     = r_tag[r_oj];
                    n_o_cos     = r_cos[r_oj];
                    n_o_total   = r_total;
                    n_o_matched = r_jtaken[r_oj];
                    n_o_last    = w_olast;
                    n_o_ovf     = r_ovf;
                    if (w_olast) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_oj = r_oj + JW'(1);
                    end
                end
            end
            ST_CLEAR: begin
                n_fc  = '0;
                n_jc  = '0;
                n_ovf = 1'b0;
                for (int i = 0; i < MAX_FERMIONS; i++) begin
                    n_ftaken[i] = 1'b0;
                end
                for (int i = 0; i < MAX_JETS; i++) begin
                    n_jtaken[i] = 1'b0;
                    n_tag[i]    = '0;
                    n_cos[i]    = '0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fc    <= '0;
            r_jc    <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < MAX_FERMIONS; i++) begin
                r_ftaken[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_JETS; i++) begin
                r_jtaken[i] <= 1'b0;
                r_tag[i]    <= '0;
                r_cos[i]    <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_fc     <= n_fc;
            r_jc     <= n_jc;
            r_ovf    <= n_ovf;
            r_ov     <= n_ov;
            r_ftaken <= n_ftaken;
            r_jtaken <= n_jtaken;
            r_tag    <= n_tag;
            r_cos    <= n_cos;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;  r_neg <= n_neg;  r_k <= n_k;  r_norm <= n_norm;
        r_is_jet <= n_is_jet;  r_final <= n_final;  r_code <= n_code;
        r_fvec <= n_fvec;  r_fcode <= n_fcode;  r_jvec <= n_jvec;
        r_f <= n_f;  r_j <= n_j;  r_dot <= n_dot;  r_zero <= n_zero;  r_dneg <= n_dneg;
        r_ad <= n_ad;  r_rad <= n_rad;  r_rem <= n_rem;  r_root <= n_root;
        r_step <= n_step;  r_num <= n_num;  r_drem <= n_drem;  r_q <= n_q;
        r_pass <= n_pass;  r_found <= n_found;  r_best <= n_best;
        r_bf <= n_bf;  r_bj <= n_bj;  r_total <= n_total;  r_oj <= n_oj;
        r_o_slot <= n_o_slot;  r_o_tag <= n_o_tag;  r_o_cos <= n_o_cos;
        r_o_total <= n_o_total;  r_o_matched <= n_o_matched;
        r_o_last <= n_o_last;  r_o_ovf <= n_o_ovf;
    end
endmodule

>>> rtl/greedy_angle_jet_matcher.sv
// Top level of the greedy angle jet matcher.
// Depends on gajm_pkg, gajm_in_if, gajm_out_if, gajm_front, gajm_back.
//
// Usage: i_in carries load items. cmd = 0 loads a true fermion (momentum and
// code; neutrino codes 12, 14, 16 are dropped), cmd = 1 loads a jet. A jet
// with final_item = 1 closes the event: every fermion/jet cosine is formed,
// jets are tagged greedily by largest cosine, and o_out delivers one result
// per held jet in jet order, the last one marked is_last. The event state is
// then cleared. Loads beyond MAX_FERMIONS or MAX_JETS are dropped and flagged.
// Timing: a two-entry queue takes items while the back end works. A kept
// load is scaled by the one-bit-a-cycle shift before its norm is formed.
// Each fermion/jet cosine takes 3 dot, 32 square root and 48 divide
// steps in one shared unit. Each greedy pass reads the cosine memory
// pair by pair (a read state, then a compare state), then one result
// leaves every cycle the receiver takes it. A stalled receiver holds the
// output register and the back end waits; the front keeps filling its queue.
// Reset (synchronous, active low) empties the queue, clears counts, tags
// and flags, and drops any result not yet taken.
module greedy_angle_jet_matcher
    import gajm_pkg::*;
#(
    parameter int MAX_FERMIONS = 4,
    parameter int MAX_JETS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gajm_in_if.sink     i_in,
    gajm_out_if.source  o_out
);
    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    gajm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready)
    );

    gajm_back #(
        .MAX_FERMIONS (MAX_FERMIONS),
        .MAX_JETS     (MAX_JETS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .o_out        (o_out)
    );

`ifndef ASSERT_OFF
    // results only name slots within the jet capacity
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, o_out.jet_slot} < 5'(MAX_JETS)))
        else $error("jet_slot beyond capacity");

    // an unmatched jet carries no tag and no cosine
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.was_matched) |-> (o_out.tag_code == 16'sd0 &&
                                                  o_out.cos_psi == 16'sd0))
        else $error("unmatched jet with nonzero tag or cosine");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid after reset");
`endif
endmodule

>>> tb/tb_gajm_types.sv
// Shared testbench types for the jet matcher bench: one load item and one
// expected jet result. Depends on gajm_pkg.
package tb_gajm_types;
    import gajm_pkg::*;

    typedef struct {
        logic               cmd;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
        logic signed [15:0] code;
        logic               fin;
    } t_load;

    typedef struct {
        logic [3:0]         slot;
        logic signed [15:0] tag;
        logic signed [15:0] cosv;
        logic signed [19:0] total;
        logic               matched;
        logic               last;
        logic               ovf;
    } t_jet_res;
endpackage

>>> tb/tb.sv
// Testbench for greedy_angle_jet_matcher: drives event loads, predicts the
// greedy cosine tagging per jet and checks every result. Depends on the RTL
// package, both channel interfaces and tb_gajm_types.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gajm_pkg::*;
    import tb_gajm_types::*;

    localparam int NF = 4;
    localparam int NJ = 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gajm_in_if  in_ch();
    gajm_out_if out_ch();

    greedy_angle_jet_matcher i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Predictor state
    logic signed [31:0] ferm_mom [NF][3];
    logic signed [15:0] ferm_code [NF];
    int                 n_ferm;
    logic signed [31:0] jet_mom [NJ][3];
    int                 n_jet;
    bit                 cap_dropped;
    t_jet_res           jet_results_due[$];
    int                 n_bad;
    bit                 stall_free;

    // Scale a vector to 15-bit magnitudes; returns 0 for a null vector
    function automatic bit scale_mom(input logic signed [31:0] v [3],
                                     output longint o [3]);
        longint mag [3];
        longint mx;
        int sh;
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = v[k] < 0 ? -longint'(v[k]) : longint'(v[k]);
            if (mag[k] > mx) mx = mag[k];
        end
        if (mx == 0) return 0;
        sh = 0;
        while ((mx >> sh) >= 32768) sh++;
        for (int k = 0; k < 3; k++) o[k] = v[k] < 0 ? -(mag[k] >> sh) : (mag[k] >> sh);
        return 1;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] open_cos(input logic signed [31:0] a [3],
                                                    input logic signed [31:0] b [3]);
        longint sa [3];
        longint sb [3];
        longint dot;
        longint unsigned na, nb, den, ad, q;
        if (!scale_mom(a, sa) || !scale_mom(b, sb)) return 16'sd0;
        dot = sa[0] * sb[0] + sa[1] * sb[1] + sa[2] * sb[2];
        na = sa[0] * sa[0] + sa[1] * sa[1] + sa[2] * sa[2];
        nb = sb[0] * sb[0] + sb[1] * sb[1] + sb[2] * sb[2];
        den = int_sqrt(na * nb);
        if (den == 0) return 16'sd0;
        ad = dot < 0 ? -dot : dot;
        q = (ad * 32768 + den / 2) / den;
        if (dot < 0) return q > 32768 ? COS_MIN : 16'(-longint'(q));
        return q > 32767 ? COS_MAX : 16'(q);
    endfunction

    // Update the event model with one accepted load
    task automatic predict_tagging(input t_load it);
        logic signed [15:0] cm [NF][NJ];
        logic signed [15:0] tags [NJ];
        logic signed [15:0] coss [NJ];
        bit f_used [NF];
        bit j_used [NJ];
        logic signed [15:0] best;
        int bf, bj, passes;
        bit found;
        int total;
        logic [15:0] ac;
        t_jet_res r;
        if (it.cmd == CMD_FERMION) begin
            ac = it.code < 0 ? -it.code : it.code;
            if (ac == CODE_NU_E || ac == CODE_NU_MU || ac == CODE_NU_TAU) return;
            if (n_ferm >= NF) begin
                cap_dropped = 1;
                return;
            end
            ferm_mom[n_ferm] = '{it.mx, it.my, it.mz};
            ferm_code[n_ferm] = it.code;
            n_ferm++;
            return;
        end
        if (n_jet >= NJ) cap_dropped = 1;
        else begin
            jet_mom[n_jet] = '{it.mx, it.my, it.mz};
            n_jet++;
        end
        if (!it.fin) return;
        for (int f = 0; f < n_ferm; f++)
            for (int j = 0; j < n_jet; j++) cm[f][j] = open_cos(ferm_mom[f], jet_mom[j]);
        for (int i = 0; i < NF; i++) f_used[i] = 0;
        for (int j = 0; j < NJ; j++) begin
            j_used[j] = 0;
            tags[j] = 0;
            coss[j] = 0;
        end
        passes = n_ferm < n_jet ? n_ferm : n_jet;
        for (int p = 0; p < passes; p++) begin
            found = 0;
            best = 0;
            bf = 0;
            bj = 0;
            for (int f = 0; f < n_ferm; f++) begin
                if (f_used[f]) continue;
                for (int j = 0; j < n_jet; j++) begin
                    if (j_used[j]) continue;
                    if (!found || cm[f][j] > best) begin
                        found = 1;
                        best = cm[f][j];
                        bf = f;
                        bj = j;
                    end
                end
            end
            if (!found) break;
            f_used[bf] = 1;
            j_used[bj] = 1;
            tags[bj] = ferm_code[bf];
            coss[bj] = best;
        end
        total = 0;
        for (int j = 0; j < n_jet; j++) total += coss[j];
        for (int j = 0; j < n_jet; j++) begin
            r.slot = 4'(j);
            r.tag = tags[j];
            r.cosv = coss[j];
            r.total = 20'(total);
            r.matched = j_used[j];
            r.last = (j + 1 == n_jet);
            r.ovf = cap_dropped;
            jet_results_due.insert(jet_results_due.size(), r);
        end
        n_ferm = 0;
        n_jet = 0;
        cap_dropped = 0;
    endtask

    // Send one load; gap drawn per item, valid stays up when no gap follows
    task automatic send_load(input t_load it);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.cmd;
        in_ch.mom_x <= it.mx;
        in_ch.mom_y <= it.my;
        in_ch.mom_z <= it.mz;
        in_ch.particle_code <= it.code;
        in_ch.final_item <= it.fin;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_tagging(it);
        @(negedge i_clk);
    endtask

    function automatic t_load mk(input logic c, input logic signed [31:0] x,
                                 input logic signed [31:0] y, input logic signed [31:0] z,
                                 input logic signed [15:0] code, input logic fin);
        t_load it;
        it.cmd = c;
        it.mx = x;
        it.my = y;
        it.mz = z;
        it.code = code;
        it.fin = fin;
        return it;
    endfunction

    function automatic logic signed [31:0] rnd_mom();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sd0;
            2: return $signed($urandom_range(0, 4000)) - 2000;
            3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom) >>> $urandom_range(0, 24);
        endcase
    endfunction

    function automatic logic signed [15:0] rnd_code();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 16'sd12 + 16'(2 * $urandom_range(0, 2))
                                           : -16'sd12 - 16'(2 * $urandom_range(0, 2));
            1: return 16'($urandom);
            default: return $signed(16'($urandom_range(1, 6))) *
                            ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
        endcase
    endfunction

    // Drop valid, then wait for every expected result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (jet_results_due.size() != 0) @(negedge i_clk);
    endtask

    // Directed: extremes, neutrinos, capacity, empty fermions, zero vectors, ties
    task automatic test_directed();
        send_load(mk(CMD_FERMION, 32'sh7FFFFFFF, 0, 0, 16'sd1, 1'b1));
        send_load(mk(CMD_FERMION, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     -16'sd2, 1'b0));
        send_load(mk(CMD_FERMION, 5, 5, 5, 16'sd14, 1'b0));
        send_load(mk(CMD_FERMION, 5, 5, 5, -16'sd12, 1'b0));
        send_load(mk(CMD_FERMION, 0, 0, 0, 16'sh7FFF, 1'b0));
        send_load(mk(CMD_FERMION, 0, 1, 0, 16'sh8000, 1'b0));
        send_load(mk(CMD_FERMION, 9, 9, 9, 16'sd3, 1'b0));
        send_load(mk(CMD_JET, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd0, 1'b0));
        send_load(mk(CMD_JET, 32'sh80000000, 0, 0, 16'sd0, 1'b0));
        send_load(mk(CMD_JET, 0, 0, 0, 16'sd0, 1'b0));
        send_load(mk(CMD_JET, 0, 1, 0, 16'hFFFF, 1'b0));
        send_load(mk(CMD_JET, 1, 1, 1, 16'sd0, 1'b1));
        // No fermions at all
        send_load(mk(CMD_FERMION, 1, 2, 3, 16'sd16, 1'b0));
        send_load(mk(CMD_JET, 1, 2, 3, 16'sd0, 1'b0));
        send_load(mk(CMD_JET, -1, 0, 0, 16'sd0, 1'b1));
        // Ties: identical fermions and jets
        send_load(mk(CMD_FERMION, 100, 0, 0, 16'sd1, 1'b0));
        send_load(mk(CMD_FERMION, 100, 0, 0, 16'sd2, 1'b0));
        send_load(mk(CMD_JET, 7, 0, 0, 16'sd0, 1'b0));
        send_load(mk(CMD_JET, 7, 0, 0, 16'sd0, 1'b1));
        // Single jet
        send_load(mk(CMD_JET, 3, -4, 0, 16'sd0, 1'b1));
        wait_drained();
    endtask

    // Random events, mostly well formed
    task automatic test_random_events(input int n_items);
        int sent, nf, nj;
        sent = 0;
        while (sent < n_items) begin
            nf = $urandom_range(0, 6);
            nj = $urandom_range(1, 6);
            for (int i = 0; i < nf; i++) begin
                send_load(mk(CMD_FERMION, rnd_mom(), rnd_mom(), rnd_mom(), rnd_code(),
                             1'($urandom)));
                sent++;
            end
            for (int i = 0; i < nj; i++) begin
                send_load(mk(CMD_JET, rnd_mom(), rnd_mom(), rnd_mom(), 16'($urandom),
                             i == nj - 1));
                sent++;
            end
            if ($urandom_range(0, 9) == 0) stall_free = ~stall_free;
        end
        stall_free = 0;
    endtask

    // Hold the sender until every result has come back
    task automatic test_drain_pause();
        send_load(mk(CMD_FERMION, 1, 0, 0, 16'sd5, 1'b0));
        send_load(mk(CMD_JET, 1, 1, 0, 16'sd0, 1'b1));
        wait_drained();
        send_load(mk(CMD_FERMION, 0, 0, -3, -16'sd5, 1'b0));
        send_load(mk(CMD_JET, 0, 0, -1, 16'sd0, 1'b1));
    endtask

    // Receiver: random stall, checks every transfer
    initial begin
        int hold;
        t_jet_res e;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = stall_free ? 0 : $urandom_range(0, 16);
            if (hold != 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (jet_results_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result slot %0d", out_ch.jet_slot);
            end else begin
                e = jet_results_due.pop_front();
                if (out_ch.jet_slot !== e.slot || out_ch.tag_code !== e.tag ||
                    out_ch.cos_psi !== e.cosv || out_ch.cos_total !== e.total ||
                    out_ch.was_matched !== e.matched || out_ch.is_last !== e.last ||
                    out_ch.overflow_seen !== e.ovf) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result mismatch: exp slot %0d tag %0d cos %0d ",
                                 e.slot, e.tag, e.cosv,
                                 "tot %0d m%0b l%0b o%0b, ",
                                 e.total, e.matched, e.last, e.ovf,
                                 "got slot %0d tag %0d cos %0d ",
                                 out_ch.jet_slot, out_ch.tag_code, out_ch.cos_psi,
                                 "tot %0d m%0b l%0b o%0b",
                                 out_ch.cos_total, out_ch.was_matched, out_ch.is_last,
                                 out_ch.overflow_seen);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        n_bad = 0;
        n_ferm = 0;
        n_jet = 0;
        cap_dropped = 0;
        stall_free = 0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_FERMION;
        in_ch.mom_x = '0;
        in_ch.mom_y = '0;
        in_ch.mom_z = '0;
        in_ch.particle_code = '0;
        in_ch.final_item = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_drain_pause();
        test_random_events(250);
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (n_bad == 0 && jet_results_due.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
